### src/arq_receive_reorder_window_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the receive reorder window
// Shared property wrappers; every property is clocked on i_clk and is
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARQ_RECEIVE_REORDER_WINDOW_TOP_DEFINES_SVH
`define ARQ_RECEIVE_REORDER_WINDOW_TOP_DEFINES_SVH

// Check a property that holds in the same cycle.
`define ARQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ARQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/arqrw_pkg.sv
// ----------------------------------------------------------------------------
// arqrw_pkg
// Types, codes and fixed sizes of the selective-repeat receive window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arqrw_pkg;

    localparam int RING_DEPTH  = 32;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int LEN_W       = 6;
    localparam int HZ_W        = 5;
    localparam int SEQ_W       = 8;
    localparam int HANDLE_W    = 8;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int ADV_W       = 5;
    localparam int COUNT_W     = 5;
    localparam int BITMAP_W    = 16;
    localparam int MAX_HORIZON = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [LEN_W-1:0] LEN_MIN       = 6'd3;
    localparam logic [LEN_W-1:0] LEN_RESET     = 6'd32;
    localparam logic [HZ_W-1:0]  HORIZON_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_RING_LENGTH   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON_WIDTH = 4'd1;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH = 2'd0,
        K_READ = 2'd1,
        K_SYNC = 2'd2,
        K_WIPE = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_OUTSIDE     = 3'd1,
        ST_DUPLICATE   = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_OUT_OF_SYNC = 3'd4,
        ST_DETACHED    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic walk_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic exec_walk;
        logic walk_go;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### src/arqrw_ctrl.sv
// ----------------------------------------------------------------------------
// arqrw_ctrl
// Sequencer: capture a transaction, run its operation, walk the head one
// slot per cycle, then hand the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arq_receive_reorder_window_top_defines.svh"

module arqrw_ctrl
    import arqrw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output t_dp_cmd       o_cmd,
    input  wire t_dp_stat i_stat
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.exec_walk ? S_WALK : S_DONE;
            end
            S_WALK: begin
                if (!i_stat.walk_go) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_WALK: begin
                o_cmd.walk_step = i_stat.walk_go;
            end
            S_DONE: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    `ARQ_ASSERT(a_finish_free, !o_cmd.finish || i_stat.out_free, "result loaded over a pending one")
    `ARQ_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == S_EXEC, "accept not run")

endmodule

`default_nettype wire

### src/arqrw_dpath.sv
// ----------------------------------------------------------------------------
// arqrw_dpath
// Slot ring, window indices, configuration registers and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "arq_receive_reorder_window_top_defines.svh"

module arqrw_dpath
    import arqrw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [SEQ_W-1:0]      i_seq,
    input  wire logic [HANDLE_W-1:0]   i_handle,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [ADV_W-1:0]           o_advanced,
    output logic [HANDLE_W-1:0]        o_handle_out,
    output logic [COUNT_W-1:0]         o_readable_count,
    output logic [BITMAP_W-1:0]        o_horizon_bitmap,
    output logic [SEQ_W-1:0]           o_next_seq
);

    // configuration
    logic [LEN_W-1:0] r_ring_len;
    logic [HZ_W-1:0]  r_horizon;

    // window state
    logic [RING_DEPTH-1:0] r_valid;
    logic [HANDLE_W-1:0]   r_slot_handle [RING_DEPTH];
    logic [IDX_W-1:0]      r_head_idx;
    logic [IDX_W-1:0]      r_tail_idx;
    logic [SEQ_W-1:0]      r_head_seq;

    // captured transaction and working result
    t_kind               r_kind;
    logic [SEQ_W-1:0]    r_seq;
    logic [HANDLE_W-1:0] r_handle;
    t_status             r_status;
    logic [HANDLE_W-1:0] r_hout;
    logic [LEN_W-1:0]    r_moved;

    // output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADV_W-1:0]    r_out_adv;
    logic [HANDLE_W-1:0] r_out_hout;
    logic [COUNT_W-1:0]  r_out_count;
    logic [BITMAP_W-1:0] r_out_map;
    logic [SEQ_W-1:0]    r_out_seq;

    logic [LEN_W-1:0]  w_len;
    logic [HZ_W-1:0]   w_hz;
    logic [LEN_W-1:0]  w_len_lim;
    logic [SEQ_W-1:0]  w_diff;
    logic              w_outside;
    logic [LEN_W:0]    w_push_sum;
    logic [IDX_W-1:0]  w_push_idx;
    logic              w_dup;
    logic [LEN_W-1:0]  w_count;
    logic [LEN_W:0]    w_gate_sum;
    logic [IDX_W-1:0]  w_gate_idx;
    logic              w_walk_go;
    logic [IDX_W-1:0]  w_head_inc;
    logic [IDX_W-1:0]  w_tail_inc;
    logic [BITMAP_W-1:0] w_map;
    logic              w_cfg_hit;

    // clamp the configured sizes
    always_comb begin
        w_len = r_ring_len;
        if (w_len < LEN_MIN) w_len = LEN_MIN;
        if (w_len > LEN_W'(RING_DEPTH)) w_len = LEN_W'(RING_DEPTH);
        w_len_lim = w_len - LEN_MIN;
        w_hz = r_horizon;
        if (w_hz > HZ_W'(MAX_HORIZON)) w_hz = HZ_W'(MAX_HORIZON);
        if ({1'b0, w_hz} > w_len_lim) w_hz = w_len_lim[HZ_W-1:0];
    end

    // push slot, distances are modulo the sequence space
    always_comb begin
        w_diff     = r_seq - r_head_seq;
        w_outside  = w_diff > SEQ_W'(w_hz);
        w_push_sum = (LEN_W+1)'(r_head_idx) + (LEN_W+1)'(w_diff[HZ_W-1:0]);
        if (w_push_sum >= {1'b0, w_len}) w_push_sum = w_push_sum - {1'b0, w_len};
        w_push_idx = w_push_sum[IDX_W-1:0];
        w_dup      = r_valid[w_push_idx];
    end

    always_comb begin
        if (r_head_idx >= r_tail_idx) begin
            w_count = LEN_W'(r_head_idx) - LEN_W'(r_tail_idx);
        end else begin
            w_count = LEN_W'(r_head_idx) + w_len - LEN_W'(r_tail_idx);
        end
    end

    // head may step while its slot is filled, fewer than ring-length steps have
    // been taken, and the tail stays clear of the slot one horizon plus one ahead
    always_comb begin
        w_gate_sum = (LEN_W+1)'(r_head_idx) + (LEN_W+1)'(w_hz) + (LEN_W+1)'(1);
        if (w_gate_sum >= {1'b0, w_len}) w_gate_sum = w_gate_sum - {1'b0, w_len};
        w_gate_idx = w_gate_sum[IDX_W-1:0];
        w_walk_go  = r_valid[r_head_idx] && (w_gate_idx != r_tail_idx) && (r_moved < w_len);
        w_head_inc = ((LEN_W'(r_head_idx) + LEN_W'(1)) == w_len) ? '0 : r_head_idx + IDX_W'(1);
        w_tail_inc = ((LEN_W'(r_tail_idx) + LEN_W'(1)) == w_len) ? '0 : r_tail_idx + IDX_W'(1);
    end

    always_comb begin
        logic [LEN_W:0] v_sum;
        w_map = '0;
        for (int i = 0; i < BITMAP_W; i++) begin
            v_sum = (LEN_W+1)'(r_head_idx) + (LEN_W+1)'(i + 1);
            if (v_sum >= {1'b0, w_len}) v_sum = v_sum - {1'b0, w_len};
            w_map[i] = ((HZ_W+1)'(i) < {1'b0, w_hz}) && r_valid[v_sum[IDX_W-1:0]];
        end
    end

    assign w_cfg_hit = i_cfg_we &&
        ((i_cfg_index == CFG_RING_LENGTH) || (i_cfg_index == CFG_HORIZON_WIDTH));

    always_comb begin
        o_stat.exec_walk = ((r_kind == K_PUSH) && !w_outside && !w_dup) ||
                           ((r_kind == K_READ) && (w_count != '0));
        o_stat.walk_go   = w_walk_go;
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_len <= LEN_RESET;
            r_horizon  <= HORIZON_RESET;
            r_valid    <= '0;
            r_head_idx <= '0;
            r_tail_idx <= '0;
            r_head_seq <= '0;
        end else if (w_cfg_hit) begin
            if (i_cfg_index == CFG_RING_LENGTH) r_ring_len <= i_cfg_data[LEN_W-1:0];
            if (i_cfg_index == CFG_HORIZON_WIDTH) r_horizon <= i_cfg_data[HZ_W-1:0];
            r_valid    <= '0;
            r_head_idx <= '0;
            r_tail_idx <= '0;
        end else if (i_cmd.exec) begin
            unique case (r_kind)
                K_PUSH: begin
                    if (!w_outside && !w_dup) r_valid[w_push_idx] <= 1'b1;
                end
                K_READ: begin
                    if (w_count != '0) begin
                        r_valid[r_tail_idx] <= 1'b0;
                        r_tail_idx          <= w_tail_inc;
                    end
                end
                K_SYNC: begin
                end
                K_WIPE: begin
                    r_valid    <= '0;
                    r_head_idx <= '0;
                    r_tail_idx <= '0;
                    r_head_seq <= r_seq;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.walk_step) begin
            r_head_idx <= w_head_inc;
            r_head_seq <= r_head_seq + SEQ_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_kind == K_PUSH) && !w_outside && !w_dup) begin
            r_slot_handle[w_push_idx] <= r_handle;
        end
    end

    // captured transaction and working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_seq    <= i_seq;
            r_handle <= i_handle;
        end
        if (i_cmd.exec) begin
            r_moved  <= '0;
            r_hout   <= '0;
            r_status <= ST_OK;
            case (r_kind)
                K_PUSH: begin
                    if (w_outside) r_status <= ST_OUTSIDE;
                    else if (w_dup) r_status <= ST_DUPLICATE;
                end
                K_READ: begin
                    if (w_count == '0) r_status <= ST_EMPTY;
                    else r_hout <= r_slot_handle[r_tail_idx];
                end
                K_SYNC: begin
                    if (w_diff != '0) begin
                        r_status <= (w_diff <= SEQ_W'(MAX_HORIZON)) ? ST_OUT_OF_SYNC
                                                                    : ST_DETACHED;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.walk_step) begin
            r_moved <= r_moved + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            r_out_adv    <= r_moved[ADV_W-1:0];
            r_out_hout   <= r_hout;
            r_out_count  <= w_count[COUNT_W-1:0];
            r_out_map    <= w_map;
            r_out_seq    <= r_head_seq;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_advanced       = r_out_adv;
    assign o_handle_out     = r_out_hout;
    assign o_readable_count = r_out_count;
    assign o_horizon_bitmap = r_out_map;
    assign o_next_seq       = r_out_seq;

    `ARQ_ASSERT(a_idx_range,
        (LEN_W'(r_head_idx) < w_len) && (LEN_W'(r_tail_idx) < w_len), "index past ring length")
    `ARQ_ASSERT(a_tail_filled, (w_count == '0) || r_valid[r_tail_idx], "readable slot at tail not filled")

endmodule

`default_nettype wire

### src/arq_receive_reorder_window_top.sv
// ----------------------------------------------------------------------------
// arq_receive_reorder_window_top
// Selective-repeat receive window: push, read, sync check and wipe.
// ----------------------------------------------------------------------------
// One transaction in gives one result out. After acceptance, a sync check, a
// wipe, a rejected push or an empty read passes through the execute and done
// states only; a push that is stored or a read that pops walks the head one
// ring slot per cycle between them, until the check that stops it. A finished
// result sits in an output register, so the next transaction is taken while
// it waits; a result stalls only when a second one is ready before the first
// has been taken.
// Configuration writes empty the ring at once and belong between transactions.
`timescale 1ns / 1ps
`default_nettype none

module arq_receive_reorder_window_top
    import arqrw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [15:0]           i_s_axis_tdata,  // sequence_req, payload_handle
    input  wire logic [7:0]            i_s_axis_tuser,  // kind
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // advanced, handle_out, readable_count, horizon_bitmap, next_seq
    output logic [47:0]                o_m_axis_tdata,
    output logic [7:0]                 o_m_axis_tuser,  // status
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [STATUS_W-1:0] w_status;
    logic [ADV_W-1:0]    w_advanced;
    logic [HANDLE_W-1:0] w_handle_out;
    logic [COUNT_W-1:0]  w_count;
    logic [BITMAP_W-1:0] w_map;
    logic [SEQ_W-1:0]    w_head_seq;

    assign o_cfg_ready = 1'b1;

    arqrw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    arqrw_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_kind           (i_s_axis_tuser[KIND_W-1:0]),
        .i_seq            (i_s_axis_tdata[SEQ_W-1:0]),
        .i_handle         (i_s_axis_tdata[SEQ_W+HANDLE_W-1:SEQ_W]),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_status         (w_status),
        .o_advanced       (w_advanced),
        .o_handle_out     (w_handle_out),
        .o_readable_count (w_count),
        .o_horizon_bitmap (w_map),
        .o_next_seq       (w_head_seq)
    );

    assign o_m_axis_tdata = {6'b0, w_head_seq, w_map, w_count, w_handle_out, w_advanced};
    assign o_m_axis_tuser = {5'b0, w_status};

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the selective-repeat receive window. Pushes, reads,
// sync checks and wipes are streamed in under several ring and horizon
// settings, with random stalls on both buses. Each accepted transaction is run
// through a bench-side window model and the expected result is queued. Every
// result leaving the block is then compared field by field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import arqrw_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  seq;
        logic [7:0]  handle;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [4:0]  advanced;
        logic [7:0]  handle_out;
        logic [4:0]  readable;
        logic [15:0] bitmap;
        logic [7:0]  head_seq;
    } t_outcome;

    typedef struct packed {
        logic [31:0]      valid;
        logic [31:0][7:0] handle;
        logic [4:0]       head_idx;
        logic [4:0]       tail_idx;
        logic [7:0]       head_seq;
        logic [7:0]       tail_seq;
        logic [5:0]       ring_len;
        logic [4:0]       horizon;
    } t_win;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    t_item                 s_item = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [47:0]           o_m_axis_tdata;
    logic [7:0]            o_m_axis_tuser;
    logic                  o_cfg_ready;

    t_item    item_q[$];
    t_outcome outcome_q[$];
    t_win     acc_win;
    t_win     gen_win;
    logic     idle_on = 1'b0;
    int       s_gap = 0;
    int       m_gap = 0;
    int       cycles = 0;
    int       mismatches = 0;

    arq_receive_reorder_window_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  ({s_item.handle, s_item.seq}),
        .i_s_axis_tuser  ({6'd0, s_item.kind}),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Window model
    // ------------------------------------------------------------------------
    function automatic int ring_span(input t_win w);
        int n;
        n = int'(w.ring_len);
        if (n < 3) n = 3;
        if (n > RING_DEPTH) n = RING_DEPTH;
        return n;
    endfunction

    function automatic int reach(input t_win w);
        int h;
        h = int'(w.horizon);
        if (h > MAX_HORIZON) h = MAX_HORIZON;
        if (h > ring_span(w) - 3) h = ring_span(w) - 3;
        return h;
    endfunction

    function automatic t_win fresh_window();
        t_win w;
        w = '0;
        w.ring_len = LEN_RESET;
        w.horizon = HORIZON_RESET;
        return w;
    endfunction

    function automatic void clear_ring(inout t_win w);
        w.valid = '0;
        w.head_idx = '0;
        w.tail_idx = '0;
    endfunction

    // Walk the head over filled slots, stopping one horizon plus one slot short of the tail.
    function automatic int advance_head(inout t_win w);
        int len;
        int hz;
        int moved;
        int g;
        len = ring_span(w);
        hz = reach(w);
        moved = 0;
        for (g = 0; g < len; g++) begin
            if (int'(w.head_idx) >= len || !w.valid[w.head_idx]) break;
            if ((int'(w.head_idx) + hz + 1) % len == int'(w.tail_idx)) break;
            w.head_idx = 5'((int'(w.head_idx) + 1) % len);
            w.head_seq = w.head_seq + 8'd1;
            moved++;
        end
        return moved;
    endfunction

    function automatic void apply_reg(inout t_win w, input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        if (idx == CFG_RING_LENGTH) begin
            w.ring_len = val[5:0];
        end else if (idx == CFG_HORIZON_WIDTH) begin
            w.horizon = val[4:0];
        end else begin
            return;
        end
        clear_ring(w);
        w.tail_seq = w.head_seq;
    endfunction

    function automatic t_outcome step_window(inout t_win w, input t_item it);
        t_outcome r;
        int len;
        int hz;
        int diff;
        int idx;
        int i;
        r = '0;
        r.status = ST_OK;
        len = ring_span(w);
        diff = int'(8'(it.seq - w.head_seq));
        case (it.kind)
            K_PUSH: begin
                idx = (int'(w.head_idx) + diff) % len;
                if (diff > reach(w)) begin
                    r.status = ST_OUTSIDE;
                end else if (w.valid[idx]) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    w.valid[idx] = 1'b1;
                    w.handle[idx] = it.handle;
                    r.advanced = 5'(advance_head(w));
                end
            end
            K_READ: begin
                if ((int'(w.head_idx) + len - int'(w.tail_idx)) % len == 0
                        || int'(w.tail_idx) >= len) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.handle_out = w.handle[w.tail_idx];
                    w.valid[w.tail_idx] = 1'b0;
                    w.tail_idx = 5'((int'(w.tail_idx) + 1) % len);
                    w.tail_seq = w.tail_seq + 8'd1;
                    r.advanced = 5'(advance_head(w));
                end
            end
            K_SYNC: begin
                if (diff != 0) r.status = (diff <= MAX_HORIZON) ? ST_OUT_OF_SYNC : ST_DETACHED;
            end
            default: begin
                clear_ring(w);
                w.head_seq = it.seq;
                w.tail_seq = it.seq;
            end
        endcase
        hz = reach(w);
        if (hz > BITMAP_W) hz = BITMAP_W;
        for (i = 0; i < hz; i++) begin
            if (w.valid[(int'(w.head_idx) + 1 + i) % len]) r.bitmap[i] = 1'b1;
        end
        r.readable = 5'((int'(w.head_idx) + len - int'(w.tail_idx)) % len);
        r.head_seq = w.head_seq;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_item(input t_kind k, input logic [7:0] sq, input logic [7:0] hd);
        t_item it;
        it.kind = k;
        it.seq = sq;
        it.handle = hd;
        void'(step_window(gen_win, it));
        item_q.push_back(it);
    endtask

    // Mostly in-window pushes and reads, with some sync checks, wipes and noise.
    task automatic queue_random(input int n);
        int k;
        int r;
        int hz;
        t_item it;
        for (k = 0; k < n; k++) begin
            hz = reach(gen_win);
            it.handle = 8'($urandom);
            it.seq = 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 55) begin
                it.kind = K_PUSH;
                it.seq = gen_win.head_seq + 8'($urandom_range(0, hz));
            end else if (r < 80) begin
                it.kind = K_READ;
            end else if (r < 88) begin
                it.kind = K_SYNC;
                if ($urandom_range(0, 1) == 1)
                    it.seq = gen_win.head_seq + 8'($urandom_range(0, MAX_HORIZON + 1));
            end else if (r < 91) begin
                it.kind = K_WIPE;
            end else begin
                it.kind = K_PUSH;
            end
            queue_item(it.kind, it.seq, it.handle);
        end
    endtask

    // Hold until every transaction is in and every result is out; sample
    // between edges so that the driver and monitor updates have landed.
    task automatic settle();
        do @(negedge i_clk);
        while (item_q.size() != 0 || s_valid || outcome_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk);
        while (!(cfg_valid && o_cfg_ready));
        cfg_valid <= 1'b0;
        apply_reg(acc_win, idx, val);
        gen_win = acc_win;
    endtask

    task automatic run_phase(input logic [7:0] len, input logic [7:0] hz, input logic idle,
                             input int n);
        write_reg(CFG_RING_LENGTH, len);
        @(posedge i_clk);
        write_reg(CFG_HORIZON_WIDTH, hz);
        idle_on = idle;
        queue_random(n);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Driver: feed queued transactions, predicting each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_gap <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) outcome_q.push_back(step_window(acc_win, s_item));
            if (!s_valid || o_s_axis_tready) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 9) == 0) begin
                    s_gap <= $urandom_range(0, 18);
                    s_valid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    s_item <= item_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: take results with random back-pressure and compare them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            m_gap <= 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding");
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", o_m_axis_tuser[2:0], want.status);
                    check_field("advanced", o_m_axis_tdata[4:0], want.advanced);
                    check_field("handle_out", o_m_axis_tdata[12:5], want.handle_out);
                    check_field("readable_count", o_m_axis_tdata[17:13], want.readable);
                    check_field("horizon_bitmap", o_m_axis_tdata[33:18], want.bitmap);
                    check_field("next_seq", o_m_axis_tdata[41:34], want.head_seq);
                    check_field("padding", {o_m_axis_tuser[7:3], o_m_axis_tdata[47:42]}, 0);
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                m_gap <= $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        acc_win = fresh_window();
        gen_win = acc_win;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full ring, full horizon: window edges, duplicates, reads, sync, wrap.
        idle_on = 1'b1;
        queue_item(K_PUSH, gen_win.head_seq, 8'hFF);
        queue_item(K_PUSH, gen_win.head_seq + 8'd16, 8'h00);
        queue_item(K_PUSH, gen_win.head_seq + 8'd17, 8'h3C);
        queue_item(K_PUSH, gen_win.head_seq - 8'd1, 8'hC3);
        queue_item(K_PUSH, gen_win.head_seq + 8'd16, 8'h81);
        queue_item(K_READ, 8'h00, 8'h00);
        queue_item(K_READ, 8'hFF, 8'hFF);
        queue_item(K_SYNC, gen_win.head_seq, 8'h00);
        queue_item(K_SYNC, gen_win.head_seq + 8'd16, 8'h00);
        queue_item(K_SYNC, gen_win.head_seq + 8'd17, 8'h00);
        queue_item(K_SYNC, gen_win.head_seq - 8'd1, 8'h00);
        queue_item(K_WIPE, 8'hFE, 8'h00);
        queue_item(K_PUSH, 8'hFF, 8'h5A);
        queue_item(K_PUSH, 8'hFE, 8'hA5);
        queue_item(K_PUSH, 8'h00, 8'h00);
        settle();

        // Smallest ring, zero horizon: head halts one slot short of the tail.
        write_reg(CFG_RING_LENGTH, 8'd0);
        queue_item(K_PUSH, gen_win.head_seq, 8'h11);
        queue_item(K_PUSH, gen_win.head_seq, 8'h22);
        queue_item(K_PUSH, gen_win.head_seq, 8'h33);
        queue_item(K_PUSH, gen_win.head_seq, 8'h44);
        queue_item(K_PUSH, gen_win.head_seq + 8'd1, 8'h55);
        repeat (4) queue_item(K_READ, 8'h00, 8'h00);
        settle();

        // Out-of-range values clamp to the top; unused indexes leave the ring alone.
        run_phase(8'hFF, 8'hFF, 1'b1, 80);
        write_reg(4'd9, 8'($urandom));
        queue_random(10);
        settle();
        run_phase(8'd8, 8'd5, 1'b0, 70);
        run_phase(8'd20, 8'd3, 1'b1, 80);
        run_phase(8'd4, 8'h1F, 1'b1, 80);
        run_phase(8'd19, 8'd0, 1'b1, 80);
        run_phase(8'd32, 8'd16, 1'b0, 90);

        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
